// ===== rtl/des_pkg.sv =====
// des_pkg: tables, permutation functions and shared types for the des block cipher
// depends on nothing; used by des_round, des_stage and des_block_cipher
package des_pkg;

  localparam int unsigned NumRounds = 16;

  // pipeline stage payload
  typedef struct packed {
    logic        dec;
    logic [31:0] l;
    logic [31:0] r;
    logic [27:0] c;
    logic [27:0] d;
  } des_state_t;

  // s-box lookup, rows of 16 packed as 4-bit values
  function automatic logic [3:0] sbox(input logic [2:0] n, input logic [5:0] v);
    logic [1:0] row;
    logic [3:0] col;
    logic [63:0] line;
    row = {v[5], v[0]};
    col = v[4:1];
    line = 64'h0;
    unique case ({n, row})
      5'd0:  line = 64'he4d12fb83a6c5907;
      5'd1:  line = 64'h0f74e2d1a6cb9538;
      5'd2:  line = 64'h41e8d62bfc973a50;
      5'd3:  line = 64'hfc8249175b3ea06d;
      5'd4:  line = 64'hf18e6b34972dc05a;
      5'd5:  line = 64'h3d47f28ec01a69b5;
      5'd6:  line = 64'h0e7ba4d158c6932f;
      5'd7:  line = 64'hd8a13f42b67c05e9;
      5'd8:  line = 64'ha09e63f51dc7b428;
      5'd9:  line = 64'hd709346a285ecbf1;
      5'd10: line = 64'hd6498f30b12c5ae7;
      5'd11: line = 64'h1ad069874fe3b52c;
      5'd12: line = 64'h7de3069a1285bc4f;
      5'd13: line = 64'hd8b56f03472c1ae9;
      5'd14: line = 64'ha690cb7df13e5284;
      5'd15: line = 64'h3f06a1d8945bc72e;
      5'd16: line = 64'h2c417ab6853fd0e9;
      5'd17: line = 64'heb2c47d150fa3986;
      5'd18: line = 64'h421bad78f9c5630e;
      5'd19: line = 64'hb8c71e2d6f09a453;
      5'd20: line = 64'hc1af92680d34e75b;
      5'd21: line = 64'haf427c9561de0b38;
      5'd22: line = 64'h9ef528c3704a1db6;
      5'd23: line = 64'h432c95fabe17608d;
      5'd24: line = 64'h4b2ef08d3c975a61;
      5'd25: line = 64'hd0b7491ae35c2f86;
      5'd26: line = 64'h14bdc37eaf680592;
      5'd27: line = 64'h6bd814a7950fe23c;
      5'd28: line = 64'hd2846fb1a93e50c7;
      5'd29: line = 64'h1fd8a374c56b0e92;
      5'd30: line = 64'h7b419ce206adf358;
      5'd31: line = 64'h21e74a8dfc90356b;
      default: line = 64'h0;
    endcase
    return line[(15 - col) * 4 +: 4];
  endfunction

  // des bit numbering: bit k (1 = msb) of a w-bit word is index w-k
  function automatic logic [63:0] perm_ip(input logic [63:0] v);
    logic [63:0] r;
    byte unsigned t [64];
    t = '{58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
          62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
          57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
          61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
    for (int i = 0; i < 64; i++) r[63 - i] = v[64 - t[i]];
    return r;
  endfunction

  function automatic logic [63:0] perm_fp(input logic [63:0] v);
    logic [63:0] r;
    byte unsigned t [64];
    t = '{40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
          38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
          36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
          34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
    for (int i = 0; i < 64; i++) r[63 - i] = v[64 - t[i]];
    return r;
  endfunction

  function automatic logic [47:0] perm_e(input logic [31:0] v);
    logic [47:0] r;
    byte unsigned t [48];
    t = '{32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
          16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
    for (int i = 0; i < 48; i++) r[47 - i] = v[32 - t[i]];
    return r;
  endfunction

  function automatic logic [31:0] perm_p(input logic [31:0] v);
    logic [31:0] r;
    byte unsigned t [32];
    t = '{16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
          2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};
    for (int i = 0; i < 32; i++) r[31 - i] = v[32 - t[i]];
    return r;
  endfunction

  function automatic logic [55:0] perm_pc1(input logic [63:0] v);
    logic [55:0] r;
    byte unsigned t [56];
    t = '{57,49,41,33,25,17,9,  1,58,50,42,34,26,18,
          10,2,59,51,43,35,27,  19,11,3,60,52,44,36,
          63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
          14,6,61,53,45,37,29,  21,13,5,28,20,12,4};
    for (int i = 0; i < 56; i++) r[55 - i] = v[64 - t[i]];
    return r;
  endfunction

  function automatic logic [47:0] perm_pc2(input logic [55:0] v);
    logic [47:0] r;
    byte unsigned t [48];
    t = '{14,17,11,24,1,5,  3,28,15,6,21,10,  23,19,12,4,26,8,  16,7,27,20,13,2,
          41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
    for (int i = 0; i < 48; i++) r[47 - i] = v[56 - t[i]];
    return r;
  endfunction

  // shift of round k (0..15): one bit in rounds 0, 1, 8, 15, else two
  function automatic logic single_shift(input int unsigned k);
    return (k == 0) || (k == 1) || (k == 8) || (k == 15);
  endfunction

endpackage

// ===== rtl/des_round.sv =====
// des_round: one feistel round with its on-the-fly key schedule step
// depends on des_pkg
module des_round #(
  parameter int unsigned RoundIdx = 0
) (
  input  des_pkg::des_state_t st_i,
  output des_pkg::des_state_t st_o
);

  logic        one;
  logic        one_back;
  logic [27:0] c_n;
  logic [27:0] d_n;
  logic [47:0] k;
  logic [47:0] x;
  logic [31:0] s;

  // encrypt rotates left before use; decrypt uses then rotates right
  assign one      = des_pkg::single_shift(RoundIdx);
  assign one_back = des_pkg::single_shift(15 - RoundIdx);
  always_comb begin
    if (!st_i.dec) begin
      c_n = one ? {st_i.c[26:0], st_i.c[27]} : {st_i.c[25:0], st_i.c[27:26]};
      d_n = one ? {st_i.d[26:0], st_i.d[27]} : {st_i.d[25:0], st_i.d[27:26]};
      k   = des_pkg::perm_pc2({c_n, d_n});
    end else begin
      k   = des_pkg::perm_pc2({st_i.c, st_i.d});
      // decrypt round i uses key 15-i, then undoes that key's rotation
      c_n = one_back ? {st_i.c[0], st_i.c[27:1]} : {st_i.c[1:0], st_i.c[27:2]};
      d_n = one_back ? {st_i.d[0], st_i.d[27:1]} : {st_i.d[1:0], st_i.d[27:2]};
    end
  end

  // round function
  assign x = des_pkg::perm_e(st_i.r) ^ k;
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      s[31 - 4 * i -: 4] = des_pkg::sbox(3'(i), x[47 - 6 * i -: 6]);
    end
  end

  assign st_o.dec = st_i.dec;
  assign st_o.l   = st_i.r;
  assign st_o.r   = st_i.l ^ des_pkg::perm_p(s);
  assign st_o.c   = c_n;
  assign st_o.d   = d_n;

endmodule

// ===== rtl/des_stage.sv =====
// des_stage: register stage holding one in-flight block, with stall support
// depends on des_pkg
module des_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                valid_i,
  input  des_pkg::des_state_t st_i,
  output logic                valid_o,
  output des_pkg::des_state_t st_o
);

  logic                valid_r;
  des_pkg::des_state_t st_r;

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_i;
    end
  end

  assign valid_o = valid_r;
  assign st_o    = st_r;

endmodule

// ===== rtl/des_block_cipher.sv =====
// des_block_cipher: fully unrolled des pipeline, one round per register stage
// depends on des_pkg, des_round, des_stage
//
// channel | dir | fields (lsb first)
// in_     | in  | tdata: data_block[63:0], cipher_key[127:64]; tuser: operation
// out_    | out | tdata: result_block[63:0]
//
// one block per cycle unless out_tready stalls; a block passes 16 round stages and an
// output register. reset clears the valid bits only. a stall on out_tready freezes
// the whole pipeline in place, so no block is lost or repeated; in_tready drops
// only while the output is held.
module des_block_cipher (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // data_block, cipher_key
  input  logic         in_tuser,   // operation
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata   // result_block
);

  localparam int unsigned N = des_pkg::NumRounds;

  logic                en;
  logic [63:0]         ip;
  logic [55:0]         cd;
  logic                vld [N+1];
  des_pkg::des_state_t st  [N+1];
  des_pkg::des_state_t rnd [N];
  logic                out_valid_r;
  logic [63:0]         out_data_r;

  // pipeline advances whenever the output slot is free or being taken
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // initial permutation and pc-1
  assign ip = des_pkg::perm_ip(in_tdata[63:0]);
  assign cd = des_pkg::perm_pc1(in_tdata[127:64]);
  assign vld[0]    = in_tvalid;
  assign st[0].dec = in_tuser;
  assign st[0].l   = ip[63:32];
  assign st[0].r   = ip[31:0];
  assign st[0].c   = cd[55:28];
  assign st[0].d   = cd[27:0];

  // sixteen round stages
  for (genvar g = 0; g < N; g++) begin : g_round
    des_round #(.RoundIdx(g)) u_round (.st_i(st[g]), .st_o(rnd[g]));
    des_stage u_stage (
      .clk(clk), .rst_n(rst_n), .en(en),
      .valid_i(vld[g]), .st_i(rnd[g]),
      .valid_o(vld[g+1]), .st_o(st[g+1])
    );
  end

  // output register with final permutation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= des_pkg::perm_fp({st[N].r, st[N].l});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench for des_block_cipher, single-block des in ecb mode
// depends on des_pkg (round count) and the des_block_cipher rtl
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned IdleStopTime = 200;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned RandomCount = 1430;
  localparam int unsigned LatencyCycles = 20;

  typedef enum logic { OpEncrypt = 1'b0, OpDecrypt = 1'b1 } des_op_e;

  typedef struct {
    des_op_e     op;
    logic [63:0] blk;
    logic [63:0] key;
    logic        known;
    logic [63:0] ans;
  } vector_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;

  logic [63:0] pending_blocks[$];
  int unsigned sent_count = 0;
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  bit          sink_calm = 1'b0;

  des_block_cipher DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // standard des tables, des bit 1 is the msb
  byte unsigned ip_tab[64] = '{58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8, 57,49,41,33,25,17,9,1,
    59,51,43,35,27,19,11,3, 61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
  byte unsigned fp_tab[64] = '{40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29, 36,4,44,12,52,20,60,28,
    35,3,43,11,51,19,59,27, 34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
  byte unsigned e_tab[48] = '{32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13,
    12,13,14,15,16,17, 16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
    28,29,30,31,32,1};
  byte unsigned p_tab[32] = '{16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
  byte unsigned pc1_tab[56] = '{57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
    10,2,59,51,43,35,27, 19,11,3,60,52,44,36, 63,55,47,39,31,23,15,
    7,62,54,46,38,30,22, 14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
  byte unsigned pc2_tab[48] = '{14,17,11,24,1,5, 3,28,15,6,21,10,
    23,19,12,4,26,8, 16,7,27,20,13,2, 41,52,31,37,47,55, 30,40,51,45,33,48,
    44,49,39,56,34,53, 46,42,50,36,29,32};
  byte unsigned shift_tab[16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
  byte unsigned sbox_tab[8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  // generic table-driven bit select, entry i picks source bit (1 = msb)
  function automatic logic [63:0] bit_select(input logic [63:0] v, input int w,
                                             input byte unsigned tab[], input int n);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < n; i++) r = {r[62:0], v[w - tab[i]]};
    return r;
  endfunction

  function automatic logic [63:0] des_cipher(input des_op_e op, input logic [63:0] blk,
                                             input logic [63:0] key);
    logic [47:0] rk[16];
    logic [27:0] c, d;
    logic [55:0] cd;
    logic [63:0] perm;
    logic [63:0] sel;
    logic [31:0] lh, rh, sb, tmp;
    logic [47:0] x;
    logic [5:0]  v;
    sel = bit_select(key, 64, pc1_tab, 56);
    cd = sel[55:0];
    c = cd[55:28];
    d = cd[27:0];
    for (int i = 0; i < des_pkg::NumRounds; i++) begin
      repeat (shift_tab[i]) begin
        c = {c[26:0], c[27]};
        d = {d[26:0], d[27]};
      end
      sel = bit_select({8'h0, c, d}, 56, pc2_tab, 48);
      rk[i] = sel[47:0];
    end
    perm = bit_select(blk, 64, ip_tab, 64);
    lh = perm[63:32];
    rh = perm[31:0];
    for (int i = 0; i < des_pkg::NumRounds; i++) begin
      sel = bit_select({32'h0, rh}, 32, e_tab, 48);
      x = sel[47:0] ^ rk[(op == OpDecrypt) ? 15 - i : i];
      sb = '0;
      for (int s = 0; s < 8; s++) begin
        v = x[47 - 6 * s -: 6];
        sb = {sb[27:0], sbox_tab[s][{v[5], v[0], v[4:1]}][3:0]};
      end
      sel = bit_select({32'h0, sb}, 32, p_tab, 32);
      tmp = lh ^ sel[31:0];
      lh = rh;
      rh = tmp;
    end
    return bit_select({rh, lh}, 64, fp_tab, 64);
  endfunction

  // directed vectors: known-answer rows carry the published result
  vector_t directed[$] = '{
    '{OpEncrypt, 64'h0123456789abcdef, 64'h133457799bbcdff1, 1'b1, 64'h85e813540f0ab405},
    '{OpDecrypt, 64'h85e813540f0ab405, 64'h133457799bbcdff1, 1'b1, 64'h0123456789abcdef},
    '{OpEncrypt, 64'h0000000000000000, 64'h0000000000000000, 1'b1, 64'h8ca64de9c1b123a7},
    '{OpEncrypt, 64'hffffffffffffffff, 64'hffffffffffffffff, 1'b1, 64'h7359b2163e4edc58},
    '{OpDecrypt, 64'h8ca64de9c1b123a7, 64'h0101010101010101, 1'b1, 64'h0000000000000000},
    '{OpEncrypt, 64'h0000000000000000, 64'hffffffffffffffff, 1'b0, 64'h0},
    '{OpEncrypt, 64'hffffffffffffffff, 64'h0000000000000000, 1'b0, 64'h0},
    '{OpDecrypt, 64'h0000000000000000, 64'h0000000000000000, 1'b0, 64'h0},
    '{OpDecrypt, 64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0, 64'h0},
    '{OpEncrypt, 64'h4e6f772069732074, 64'h0123456789abcdef, 1'b1, 64'h3fa40e8a984d4815},
    // weak and semi-weak keys pass through unflagged
    '{OpEncrypt, 64'h0123456789abcdef, 64'hfefefefefefefefe, 1'b0, 64'h0},
    '{OpDecrypt, 64'h0123456789abcdef, 64'h1f1f1f1f0e0e0e0e, 1'b0, 64'h0},
    '{OpEncrypt, 64'h0123456789abcdef, 64'h01fe01fe01fe01fe, 1'b0, 64'h0},
    // wrong parity bits only
    '{OpEncrypt, 64'h0123456789abcdef, 64'h123456789abcdef0, 1'b0, 64'h0},
    '{OpEncrypt, 64'h0123456789abcdef, 64'h133457799bbcdff0, 1'b1, 64'h85e813540f0ab405},
    '{OpEncrypt, 64'h8000000000000000, 64'h0101010101010101, 1'b0, 64'h0},
    '{OpEncrypt, 64'h0000000000000001, 64'h8000000000000000, 1'b0, 64'h0},
    '{OpDecrypt, 64'haaaaaaaa55555555, 64'h5555aaaa5555aaaa, 1'b0, 64'h0}};

  // a known-answer row overrides the predictor only where it was typed in
  task automatic send_block(input vector_t vec);
    logic [63:0] want;
    want = vec.known ? vec.ans : des_cipher(vec.op, vec.blk, vec.key);
    in_tvalid <= 1'b1;
    in_tdata  <= {vec.key, vec.blk};
    in_tuser  <= vec.op;
    do @(posedge clk); while (!in_tready);
    pending_blocks.push_back(want);
    sent_count++;
  endtask

  // sender gaps in random bursts, none in the last stretch
  task automatic maybe_gap(input int unsigned idx);
    if (idx + IdleStopTime < RandomCount && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_blocks.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_tdata);
        error_count++;
      end else begin
        if (out_tdata !== pending_blocks[0]) begin
          $display("%0t: result_block expected %h actual %h",
                   $time, pending_blocks[0], out_tdata);
          error_count++;
        end
        void'(pending_blocks.pop_front());
      end
    end
  end

  // receiver stalls in random bursts
  initial begin
    @(posedge rst_n);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!sink_calm) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end
  end

  // watchdog on cycles with no request accepted on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("des_block_cipher test failed");
      $finish;
    end
  end

  initial begin
    vector_t vec;
    logic [1:0] pick;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) begin
      send_block(directed[i]);
      maybe_gap(i);
    end
    for (int unsigned i = 0; i < RandomCount; i++) begin
      if (i + IdleStopTime >= RandomCount) sink_calm = 1'b1;
      pick = 2'($urandom_range(0, 3));
      vec.op = des_op_e'($urandom_range(0, 1));
      vec.blk = {$urandom, $urandom};
      vec.key = {$urandom, $urandom};
      if (pick == 0) vec.blk = {2{$urandom_range(0, 1) ? 32'hffffffff : 32'h0}} ^
                               (64'h1 << $urandom_range(0, 63));
      if (pick == 1) vec.key = {2{$urandom_range(0, 1) ? 32'hffffffff : 32'h0}} ^
                               (64'h1 << $urandom_range(0, 63));
      vec.known = 1'b0;
      vec.ans = '0;
      send_block(vec);
      maybe_gap(i);
    end
    in_tvalid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (LatencyCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("des_block_cipher test passed");
    end else begin
      $display("des_block_cipher test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/des_pkg.sv
rtl/des_round.sv
rtl/des_stage.sv
rtl/des_block_cipher.sv
tb/tb_top.sv
